@@ design/flow_average_and_scale_assert.svh @@
// assertion helpers for the flow averaging block
`ifndef FLOW_AVERAGE_AND_SCALE_ASSERT_SVH
`define FLOW_AVERAGE_AND_SCALE_ASSERT_SVH

// condition implies consequence in the same cycle
`define FAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("flow_average_and_scale check failed");

// condition implies consequence in the next cycle
`define FAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flow_average_and_scale check failed");

`endif

@@ design/fas_pkg.sv @@
`timescale 1ns / 1ps
package fas_pkg;

	localparam int FLOW_W  = 16;
	localparam int ALT_W   = 16;
	localparam int FOCAL_W = 12;
	localparam int VEL_W   = 32;

	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 12'd256;

	typedef struct packed {
		logic signed [FLOW_W-1:0] flow_x;
		logic signed [FLOW_W-1:0] flow_y;
		logic        [ALT_W-1:0]  altitude;
	} fas_in_t;

	typedef struct packed {
		logic signed [FLOW_W-1:0] mean_x;
		logic signed [FLOW_W-1:0] mean_y;
		logic signed [VEL_W-1:0]  vel_x;
		logic signed [VEL_W-1:0]  vel_y;
	} fas_out_t;

	typedef logic [FOCAL_W-1:0] fas_focal_t;

endpackage

@@ design/fas_chan_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel with a typed payload
interface fas_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/flow_average_and_scale.sv @@
`timescale 1ns / 1ps
// Moving average of optical flow with conversion to ground velocity. Each flow transaction
// (flow_x, flow_y, altitude) yields one result transaction carrying the mean of the last
// WINDOW_LEN samples per axis (divided by the number held while the window fills, truncated
// toward zero) and that mean times altitude divided by focal_length (zero read as one),
// truncated toward zero, in 1/16 mm per second. The block takes one sample at a time; two
// restoring dividers, one per axis and shared by the mean and velocity divisions, retire two
// quotient bits a cycle. A finished result waits in the output register while the next
// sample is taken. focal_length is written on cfg and resets to 256; the user must write it
// only while the block is idle, which the block itself does not enforce. The window samples
// sit in a small synchronous RAM; the fill count keeps never-written slots out of the sums,
// so no clearing pass follows reset.
module flow_average_and_scale #(
	parameter int WINDOW_LEN = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	fas_chan_if.sink   flow,
	fas_chan_if.source result,
	fas_chan_if.sink   cfg
);
	import fas_pkg::*;

	// sum of up to WINDOW_LEN signed samples
	localparam int SUM_W      = FLOW_W + $clog2(WINDOW_LEN + 1);
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
	localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	// mean division runs over the sum width rounded up to whole bit pairs
	localparam int MEAN_STEPS = ((SUM_W + 1) / 2) * 2;
	localparam int MEAN_SHIFT = VEL_W - MEAN_STEPS;
	localparam int DVD_W      = VEL_W;
	localparam int REM_W      = FOCAL_W + 1;
	localparam int MAG_W      = FLOW_W + 1;
	localparam int PROD_W     = MAG_W + ALT_W;
	localparam int STEP_W     = 5;
	localparam int RAM_W      = 2 * FLOW_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MLOAD,
		S_MDIV,
		S_MUL,
		S_VDIV,
		S_OUT
	} state_t;

	state_t state_q;

	// control and window bookkeeping
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        fill_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [SUM_W-1:0] sum_q [2];
	fas_focal_t              focal_q;
	logic                    out_valid_q;
	fas_out_t                out_q;

	// datapath, lane 0 is x and lane 1 is y
	logic signed [FLOW_W-1:0] sample_q [2];
	logic [ALT_W-1:0]         alt_q;
	logic [DVD_W-1:0]         dvd_q [2];
	logic [REM_W-1:0]         rem_q [2];
	logic                     neg_q [2];
	logic [FOCAL_W-1:0]       dvs_q;
	logic signed [FLOW_W-1:0] mean_q [2];

	logic                    flow_acc;
	logic                    window_full;
	logic [RAM_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0] sum_next [2];
	logic [SUM_W-1:0]        sum_abs [2];
	logic [DVD_W-1:0]        dvd_next [2];
	logic [REM_W-1:0]        rem_next [2];
	logic [PROD_W-1:0]       prod [2];
	logic [FOCAL_W-1:0]      focal_div;
	logic signed [MAG_W-1:0] mean_wide [2];

	assign flow_acc    = flow.valid && flow.ready;
	assign flow.ready  = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign window_full = (fill_q == CNT_W'(WINDOW_LEN));
	assign focal_div   = (focal_q == '0) ? FOCAL_W'(1) : focal_q;

	// window store, both axes side by side; the read for a sample is issued on its
	// transaction and the write back follows in the next cycle (S_READ), before any further read
	fas_ram #(
		.WIDTH (RAM_W),
		.DEPTH (WINDOW_LEN),
		.AW    (SLOT_W)
	) u_window (
		.clk     (clk),
		.wr_en   (state_q == S_READ),
		.wr_addr (slot_q),
		.wr_data ({sample_q[1], sample_q[0]}),
		.rd_en   (flow_acc),
		.rd_addr (slot_q),
		.rd_data (ram_rdata)
	);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic signed [SUM_W-1:0] old_ext;
			logic signed [SUM_W-1:0] new_ext;
			logic [DVD_W-1:0]        d;
			logic [REM_W-1:0]        r;
			logic [FLOW_W-1:0]       old_raw;
			old_raw = ram_rdata[l*FLOW_W +: FLOW_W];
			old_ext = {{(SUM_W-FLOW_W){old_raw[FLOW_W-1]}}, old_raw};
			new_ext = {{(SUM_W-FLOW_W){sample_q[l][FLOW_W-1]}}, sample_q[l]};
			// the oldest sample leaves the sum only once the window is full
			sum_next[l] = window_full ? (sum_q[l] + new_ext - old_ext) : (sum_q[l] + new_ext);
			sum_abs[l]  = sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);
			// two restoring division steps
			d = dvd_q[l];
			r = rem_q[l];
			for (int s = 0; s < 2; s++) begin
				r = {r[REM_W-2:0], d[DVD_W-1]};
				d = {d[DVD_W-2:0], 1'b0};
				if (r >= {1'b0, dvs_q}) begin
					r    = r - {1'b0, dvs_q};
					d[0] = 1'b1;
				end
			end
			dvd_next[l]  = d;
			rem_next[l]  = r;
			prod[l]      = dvd_q[l][MAG_W-1:0] * alt_q;
			mean_wide[l] = neg_q[l] ? -$signed(dvd_q[l][MAG_W-1:0]) : $signed(dvd_q[l][MAG_W-1:0]);
		end
	end

	// state machine, window bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			focal_q     <= FOCAL_RESET;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				focal_q <= cfg.data;
			end
			// in S_OUT the handover below decides the valid flag
			if (out_valid_q && result.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (flow_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					sum_q[0] <= sum_next[0];
					sum_q[1] <= sum_next[1];
					if (!window_full) begin
						fill_q <= fill_q + 1'b1;
					end
					slot_q  <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
					state_q <= S_MLOAD;
				end
				S_MLOAD: begin
					step_q  <= STEP_W'(MEAN_STEPS / 2);
					state_q <= S_MDIV;
				end
				S_MDIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q  <= STEP_W'(DVD_W / 2);
					state_q <= S_VDIV;
				end
				S_VDIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the previous result has gone
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_q.mean_x <= mean_q[0];
						out_q.mean_y <= mean_q[1];
						// magnitude stays below 2^31, so the signed range always holds it
						out_q.vel_x  <= neg_q[0] ? -$signed(dvd_q[0]) : $signed(dvd_q[0]);
						out_q.vel_y  <= neg_q[1] ? -$signed(dvd_q[1]) : $signed(dvd_q[1]);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// shared dividers and multipliers
	always_ff @(posedge clk) begin
		if (flow_acc) begin
			sample_q[0] <= flow.data.flow_x;
			sample_q[1] <= flow.data.flow_y;
			alt_q       <= flow.data.altitude;
		end
		for (int l = 0; l < 2; l++) begin
			case (state_q)
				S_MLOAD: begin
					// sign of the mean and of the velocity follows the sum
					neg_q[l] <= sum_q[l][SUM_W-1];
					dvd_q[l] <= DVD_W'(sum_abs[l]) << MEAN_SHIFT;
					rem_q[l] <= '0;
				end
				S_MDIV, S_VDIV: begin
					dvd_q[l] <= dvd_next[l];
					rem_q[l] <= rem_next[l];
				end
				S_MUL: begin
					mean_q[l] <= mean_wide[l][FLOW_W-1:0];
					dvd_q[l]  <= prod[l][DVD_W-1:0];
					rem_q[l]  <= '0;
				end
				default: begin
				end
			endcase
		end
		case (state_q)
			S_MLOAD: dvs_q <= FOCAL_W'(fill_q);
			S_MUL:   dvs_q <= focal_div;
			default: begin
			end
		endcase
	end

`include "flow_average_and_scale_assert.svh"

	`FAS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(WINDOW_LEN))
	`FAS_ASSERT_NOW(a_slot_bound, 1'b1, slot_q <= SLOT_W'(WINDOW_LEN - 1))
	`FAS_ASSERT_NEXT(a_accept_starts, flow_acc, state_q == S_READ)
	`FAS_ASSERT_NOW(a_result_from_out, $rose(out_valid_q), $past(state_q) == S_OUT)

endmodule

@@ design/fas_ram.sv @@
`timescale 1ns / 1ps
// single write port, single registered read port
module fas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 5,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
